// File: rtl/spgm_pkg.sv
// ----------------------------------------------------------------------------
// spgm_pkg
// shared constants and types of the stereo pan/gain mixer
// ----------------------------------------------------------------------------
package spgm_pkg;

   // channel set and coefficient registers
   localparam int NUM_CHANNELS  = 8;
   localparam int NUM_COEF_REGS = 8;
   localparam int CHAN_W        = 3;
   localparam int COEF_W        = 51;

   // csr port: 64-bit registers at byte address 8*i
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_LO = 3;

   // coefficient word layout
   localparam int GAIN_W    = 16;
   localparam int PAN_W     = 17;
   localparam int GAIN_LO   = 0;
   localparam int PAN_L_LO  = 16;
   localparam int PAN_R_LO  = 33;
   localparam int STEREO_B  = 50;

   // reset: gain 1.0, pan_l 0.5, pan_r 1.0, mono
   localparam logic [COEF_W-1:0] COEF_RESET = 51'h2_0000_8000_1000;

   // Q1.16 pan constants
   localparam logic [PAN_W-1:0] PAN_ONE  = 17'h10000;
   localparam logic [PAN_W-1:0] PAN_HALF = 17'h08000;

   // sample and accumulator widths
   localparam int SMP_W   = 16;
   localparam int SUM_W   = 32;
   localparam int FRAC_B  = 12;
   localparam int MPROD_W = SMP_W + GAIN_W + 1;
   localparam int CONTR_W = MPROD_W - FRAC_B;

   // side gain divider: quotient never exceeds the gain
   localparam int DIV_STEPS = GAIN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [NUM_COEF_REGS-1:0][COEF_W-1:0] coef_array_type;

   typedef struct packed {
      logic [CHAN_W-1:0]       channel;
      logic                    side;
      logic signed [SMP_W-1:0] sample;
      logic                    silent;
      logic                    last;
   } item_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic coef_mul;
      logic div_step;
      logic mul_left;
      logic mul_right;
      logic acc_left;
      logic acc_right;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic active;
      logic last;
   } stat_type;

endpackage

// File: rtl/spgm_csr.sv
// ----------------------------------------------------------------------------
// spgm_csr
// per-channel coefficient registers behind the csr port
// ----------------------------------------------------------------------------
module spgm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spgm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [spgm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [spgm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output spgm_pkg::coef_array_type           coefs
);

   spgm_pkg::coef_array_type coef_ff;
   spgm_pkg::coef_array_type coef_in;
   logic [spgm_pkg::CHAN_W-1:0] reg_idx;
   logic                        wr_en;

   assign reg_idx    = csr_paddr[spgm_pkg::CSR_ADDR_W-1:spgm_pkg::CSR_IDX_LO];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         coef_in[reg_idx] = csr_pwdata[spgm_pkg::COEF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < spgm_pkg::NUM_COEF_REGS; i++) begin
            coef_ff[i] <= spgm_pkg::COEF_RESET;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign csr_prdata = {{(spgm_pkg::CSR_DATA_W-spgm_pkg::COEF_W){1'b0}}, coef_ff[reg_idx]};
   assign coefs      = coef_ff;

endmodule

// File: rtl/spgm_dp.sv
// ----------------------------------------------------------------------------
// spgm_dp
// datapath: coefficient pick, side gain divider, gain multiply, accumulators
// ----------------------------------------------------------------------------
module spgm_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  spgm_pkg::item_type                item,
   input  spgm_pkg::coef_array_type          coefs,
   input  spgm_pkg::cmd_type                 cmd,
   output spgm_pkg::stat_type                stat,
   output logic signed [spgm_pkg::SMP_W-1:0] left_out,
   output logic signed [spgm_pkg::SMP_W-1:0] right_out
);

   localparam int GW = spgm_pkg::GAIN_W;
   localparam int PW = spgm_pkg::PAN_W;
   localparam int SW = spgm_pkg::SUM_W;
   localparam int CW = spgm_pkg::CONTR_W;
   localparam int OW = spgm_pkg::SMP_W;

   function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] acc,
                                                     input logic signed [CW-1:0] inc);
      logic signed [SW:0] s;
      s = {acc[SW-1], acc} + {{(SW+1-CW){inc[CW-1]}}, inc};
      if (s[SW] != s[SW-1]) begin
         sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sat_add = s[SW-1:0];
      end
   endfunction

   function automatic logic signed [OW-1:0] sat16(input logic signed [SW-1:0] v);
      if (v[SW-1:OW-1] == {(SW-OW+1){v[SW-1]}}) begin
         sat16 = v[OW-1:0];
      end else begin
         sat16 = v[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end
   endfunction

   // latched item
   logic [GW-1:0]                 gain_ff;
   logic [PW-1:0]                 pan_ff;
   logic signed [OW-1:0]          smp_ff;
   logic                          active_ff;
   logic                          last_ff;
   // divider
   logic                          low_ff;
   logic                          zero_ff;
   logic [PW-1:0]                 dvs_ff;
   logic [PW-1:0]                 rem_ff;
   logic [GW-1:0]                 quo_ff;
   // accumulate
   logic signed [spgm_pkg::MPROD_W-1:0] mprod_ff;
   logic signed [SW-1:0]          left_sum_ff;
   logic signed [SW-1:0]          right_sum_ff;
   logic signed [OW-1:0]          left_out_ff;
   logic signed [OW-1:0]          right_out_ff;

   logic [spgm_pkg::COEF_W-1:0]   coef;
   logic [PW-1:0]                 one_minus;
   logic                          pan_low;
   logic [PW-1:0]                 mul_x;
   logic [GW+PW-1:0]              coef_prod;
   logic [PW:0]                   trial;
   logic [GW-1:0]                 gl;
   logic [GW-1:0]                 gr;
   logic signed [CW-1:0]          contrib;

   assign coef = coefs[item.channel];

   // x is pan below centre, else 1.0 - pan; the other term is the divisor
   assign one_minus = spgm_pkg::PAN_ONE - pan_ff;
   assign pan_low   = pan_ff < spgm_pkg::PAN_HALF;
   assign mul_x     = pan_low ? pan_ff : one_minus;
   assign coef_prod = gain_ff * mul_x;

   assign trial = {rem_ff, quo_ff[GW-1]} - {1'b0, dvs_ff};

   // louder side keeps the full gain
   assign gl = zero_ff ? '0 : (low_ff ? gain_ff : quo_ff);
   assign gr = zero_ff ? '0 : (low_ff ? quo_ff : gain_ff);

   assign contrib = mprod_ff[spgm_pkg::MPROD_W-1:spgm_pkg::FRAC_B];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gain_ff   <= coef[spgm_pkg::GAIN_LO +: GW];
         pan_ff    <= (coef[spgm_pkg::STEREO_B] && item.side) ?
                      coef[spgm_pkg::PAN_R_LO +: PW] : coef[spgm_pkg::PAN_L_LO +: PW];
         smp_ff    <= item.sample;
         active_ff <= !item.silent && (32'(item.channel) < spgm_pkg::NUM_CHANNELS);
         last_ff   <= item.last;
      end
      if (cmd.coef_mul) begin
         low_ff  <= pan_low;
         zero_ff <= pan_ff > spgm_pkg::PAN_ONE;
         dvs_ff  <= pan_low ? one_minus : pan_ff;
         // upper half starts below the divisor as the quotient fits the gain width
         rem_ff  <= {1'b0, coef_prod[2*GW-1:GW]};
         quo_ff  <= coef_prod[GW-1:0];
      end
      if (cmd.div_step) begin
         if (!trial[PW]) begin
            rem_ff <= trial[PW-1:0];
         end else begin
            rem_ff <= {rem_ff[PW-2:0], quo_ff[GW-1]};
         end
         quo_ff <= {quo_ff[GW-2:0], ~trial[PW]};
      end
      if (cmd.mul_left) begin
         mprod_ff <= smp_ff * $signed({1'b0, gl});
      end
      if (cmd.mul_right) begin
         mprod_ff <= smp_ff * $signed({1'b0, gr});
      end
   end

   // running sums and the output pair, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
         left_out_ff  <= '0;
         right_out_ff <= '0;
      end else begin
         if (cmd.acc_left) begin
            left_sum_ff <= sat_add(left_sum_ff, contrib);
         end
         if (cmd.acc_right) begin
            right_sum_ff <= sat_add(right_sum_ff, contrib);
         end
         if (cmd.emit) begin
            left_out_ff  <= sat16(left_sum_ff);
            right_out_ff <= sat16(right_sum_ff);
            left_sum_ff  <= '0;
            right_sum_ff <= '0;
         end
      end
   end

   assign stat.active = active_ff;
   assign stat.last   = last_ff;
   assign left_out    = left_out_ff;
   assign right_out   = right_out_ff;

endmodule

// File: rtl/spgm_ctrl.sv
// ----------------------------------------------------------------------------
// spgm_ctrl
// sequencer: load, gain product, divider steps, two multiply-adds, emit
// ----------------------------------------------------------------------------
module spgm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  spgm_pkg::stat_type stat,
   output spgm_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_MULL = 3'd3;
   localparam logic [2:0] ST_MULR = 3'd4;
   localparam logic [2:0] ST_ADDR = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;

   localparam logic [spgm_pkg::DIV_CNT_W-1:0] CNT_LAST =
      spgm_pkg::DIV_CNT_W'(spgm_pkg::DIV_STEPS - 1);

   logic [2:0]                        state_ff, state_in;
   logic [spgm_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.coef_mul = 1'b1;
            cnt_in       = '0;
            state_in     = stat.active ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MULL;
            end
         end
         ST_MULL: begin
            cmd.mul_left = 1'b1;
            state_in     = ST_MULR;
         end
         ST_MULR: begin
            cmd.mul_right = 1'b1;
            cmd.acc_left  = 1'b1;
            state_in      = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.acc_right = 1'b1;
            state_in      = ST_FIN;
         end
         ST_FIN: begin
            if (!stat.last) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/stereo_pan_gain_mixer.sv
// ----------------------------------------------------------------------------
// stereo_pan_gain_mixer
// mixes mono and stereo channel samples into one saturated stereo pair
// ----------------------------------------------------------------------------
// Each request is one sample of one channel buffer. A request that counts
// (not silent, channel in range) goes through the load, the gain times pan
// product, the restoring divider that derives the quieter side's gain (one
// quotient bit per cycle), a left and a right multiply on the single shared
// sample multiplier, the last accumulate and a finish step before the next
// request can be taken. A silent or out-of-range request goes from the gain
// product straight to the finish step. On a request flagged tlast the two
// running sums are saturated to 16 bits and parked in the output register,
// and the sums clear; the block goes on accepting requests while that
// result waits, and only a later tlast request stalls until the previous
// result has been taken. Coefficients (gain Q4.12, pan_l and pan_r Q1.16,
// stereo flag) are written through the csr port, one 64-bit register per
// channel at byte address 8*channel, and should only change while idle.
// ----------------------------------------------------------------------------
module stereo_pan_gain_mixer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // channel[2:0], side[3], sample[19:4], zero pad
   input  logic                            req_tuser,  // silent
   input  logic                            req_tlast,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // left_out[15:0], right_out[31:16]
   // csr port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [spgm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [spgm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [spgm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   spgm_pkg::coef_array_type coefs;
   spgm_pkg::item_type       item;
   spgm_pkg::cmd_type        cmd;
   spgm_pkg::stat_type       stat;
   logic signed [15:0]       left_out;
   logic signed [15:0]       right_out;

   // unpack the request fields
   assign item.channel = req_tdata[2:0];
   assign item.side    = req_tdata[3];
   assign item.sample  = req_tdata[19:4];
   assign item.silent  = req_tuser;
   assign item.last    = req_tlast;

   // coefficient registers
   spgm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   // sequencer
   spgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic, running sums start at zero after reset
   spgm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .coefs     (coefs),
      .cmd       (cmd),
      .stat      (stat),
      .left_out  (left_out),
      .right_out (right_out)
   );

   assign rsp_tdata = {right_out, left_out};

endmodule

// File: rtl/spgm_checker.sv
// ----------------------------------------------------------------------------
// spgm_checker
// port-level checks of the stereo pan/gain mixer, bound to the top level
// ----------------------------------------------------------------------------
module spgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // every request keeps the block busy, so req_tready stays low after it is accepted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request accepted too soon after the previous one");

   // a request without tlast never creates a response
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !rsp_tvalid |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("response without a tlast request");

   // nothing pending right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind stereo_pan_gain_mixer spgm_checker u_spgm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: dv/spgm_mix_checker.sv
// ----------------------------------------------------------------------------
// spgm_mix_checker
// predicts the mixed stereo pair of each frame and checks the response stream
// ----------------------------------------------------------------------------
// Watches the csr, request and response channels of the mixer. It keeps its
// own copy of the coefficients and of both running sums. Each tlast request
// queues one expected left/right pair, and each response is checked against
// the oldest queued pair.
// ----------------------------------------------------------------------------
module spgm_mix_checker
   import spgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    mixes_pending
);

   localparam longint SUM_MAX     = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SUM_MIN     = -SUM_MAX - 1;

   typedef struct {
      logic signed [SMP_W-1:0] left;
      logic signed [SMP_W-1:0] right;
   } stereo_mix_type;

   stereo_mix_type          mix_expect_q[$];
   logic [COEF_W-1:0]       coef_copy[NUM_COEF_REGS];
   logic signed [SUM_W-1:0] left_acc;
   logic signed [SUM_W-1:0] right_acc;

   // louder side keeps the full gain, quieter side gets gain scaled by the ratio
   function automatic void derive_side_gains(input  logic [GAIN_W-1:0] gain,
                                             input  logic [PAN_W-1:0]  pan,
                                             output logic [GAIN_W-1:0] gain_l,
                                             output logic [GAIN_W-1:0] gain_r);
      longint unsigned g;
      longint unsigned p;
      longint unsigned one;
      g      = 64'(gain);
      p      = 64'(pan);
      one    = 64'(PAN_ONE);
      gain_l = '0;
      gain_r = '0;
      if (p <= one) begin
         if (p < 64'(PAN_HALF)) begin
            gain_l = gain;
            gain_r = GAIN_W'((g * p) / (one - p));
         end else begin
            gain_r = gain;
            gain_l = GAIN_W'((g * (one - p)) / p);
         end
      end
   endfunction

   // sample times Q4.12 gain, floored back to Q1.15
   function automatic longint scaled_sample(input logic signed [SMP_W-1:0] smp,
                                            input logic [GAIN_W-1:0]       g);
      longint prod;
      prod = longint'(smp) * longint'({1'b0, g});
      return prod >>> FRAC_B;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_accumulate(
      input logic signed [SUM_W-1:0] acc, input longint addend);
      longint total;
      total = longint'(acc) + addend;
      if (total > SUM_MAX) return SUM_W'(SUM_MAX);
      if (total < SUM_MIN) return SUM_W'(SUM_MIN);
      return SUM_W'(total);
   endfunction

   function automatic logic signed [SMP_W-1:0] clip_q15(input logic signed [SUM_W-1:0] v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[SMP_W-1:0];
   endfunction

   task automatic check_side(input string side_name, input logic signed [SMP_W-1:0] want,
                             input logic signed [SMP_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mix mismatch, expected %0d, got %0d",
                  $time, side_name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      logic [CHAN_W-1:0]       ch;
      logic                    side_b;
      logic signed [SMP_W-1:0] smp;
      logic [COEF_W-1:0]       coef;
      logic [PAN_W-1:0]        pan;
      logic [GAIN_W-1:0]       gain_l;
      logic [GAIN_W-1:0]       gain_r;
      stereo_mix_type          want;
      stereo_mix_type          got;
      if (reset) begin
         for (int i = 0; i < NUM_COEF_REGS; i++) coef_copy[i] = COEF_RESET;
         left_acc  = '0;
         right_acc = '0;
         mix_expect_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            coef_copy[csr_paddr[CSR_ADDR_W-1:CSR_IDX_LO]] = csr_pwdata[COEF_W-1:0];

         // responses first: a pair queued at this edge cannot leave at it
         if (rsp_tvalid && rsp_tready) begin
            got.left  = rsp_tdata[15:0];
            got.right = rsp_tdata[31:16];
            if (mix_expect_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected mix, expected none, got left %0d right %0d",
                        $time, got.left, got.right);
            end else begin
               want = mix_expect_q.pop_front();
               check_side("left", want.left, got.left);
               check_side("right", want.right, got.right);
            end
         end

         if (req_tvalid && req_tready) begin
            ch     = req_tdata[2:0];
            side_b = req_tdata[3];
            smp    = req_tdata[19:4];
            if (!req_tuser && ch < NUM_CHANNELS) begin
               coef = coef_copy[ch];
               pan  = (coef[STEREO_B] && side_b) ? coef[PAN_R_LO +: PAN_W]
                                                 : coef[PAN_L_LO +: PAN_W];
               derive_side_gains(coef[GAIN_LO +: GAIN_W], pan, gain_l, gain_r);
               left_acc  = sat_accumulate(left_acc, scaled_sample(smp, gain_l));
               right_acc = sat_accumulate(right_acc, scaled_sample(smp, gain_r));
            end
            if (req_tlast) begin
               want.left  = clip_q15(left_acc);
               want.right = clip_q15(right_acc);
               mix_expect_q = {mix_expect_q, want};
               left_acc  = '0;
               right_acc = '0;
            end
         end
      end
      mixes_pending = mix_expect_q.size();
   end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// random and directed test of the stereo pan/gain mixer
// ----------------------------------------------------------------------------
// Drives sample requests and coefficient writes into the mixer while a
// separate checker predicts every mixed stereo pair. Runs a directed set of
// corner cases, then random frames under three idling patterns, plus one
// long frame of full-scale samples that drives both outputs hard into clipping.
// ----------------------------------------------------------------------------
module tb_top;
   import spgm_pkg::*;

   // long enough to cover the longest request still in flight
   localparam int DRAIN_CYCLES    = 40;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT     = 3000;
   // long receiver hold-off so the parked result blocks the next tlast
   localparam int RSP_HOLD_CYCLES = 400;
   // full-scale requests in one long frame, far past the 16-bit output range
   localparam int OVERFLOW_ITEMS  = 300;
   localparam int PHASE_ITEMS     = 420;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // channel[2:0], side[3], sample[19:4], zero pad
   logic                  req_tuser;   // silent
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [31:0]           rsp_tdata;   // left_out[15:0], right_out[31:16]
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int mixes_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;
   bit hold_request;

   stereo_pan_gain_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   spgm_mix_checker mix_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .mixes_pending (mixes_pending)
   );

   // 8 unit clock period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // reset asserted at the start, then released on a falling edge
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // response side: random back-pressure, plus one long hold-off on request
   initial begin : receiver
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // hang detection: any accepted request, response or csr access is progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // one sample request; returns at the falling edge after the handshake with
   // tvalid still high, so back-to-back requests need no second assignment
   task automatic send_request(input logic [CHAN_W-1:0] ch, input logic side_b,
                               input logic signed [SMP_W-1:0] smp,
                               input logic silent, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, smp, side_b, ch};
      req_tuser  <= silent;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // setup then access phase, then back to idle so writes never overlap
   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx << CSR_IDX_LO);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // stop offering, let every queued mix come back, then let the block settle
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (mixes_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] make_coef(input logic [GAIN_W-1:0] gain,
                                                       input logic [PAN_W-1:0] pan_l,
                                                       input logic [PAN_W-1:0] pan_r,
                                                       input logic stereo);
      logic [CSR_DATA_W-1:0] word;
      word                       = '0;
      word[GAIN_LO +: GAIN_W]    = gain;
      word[PAN_L_LO +: PAN_W]    = pan_l;
      word[PAN_R_LO +: PAN_W]    = pan_r;
      word[STEREO_B]             = stereo;
      return word;
   endfunction

   // pan biased toward the boundaries: hard left, centre, hard right, beyond 1.0
   function automatic logic [PAN_W-1:0] pick_pan();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return PAN_HALF;
         2: return PAN_ONE;
         3: return PAN_W'($urandom_range(32'h1_0001, 32'h1_FFFF));
         4: return PAN_W'(PAN_HALF - 1);
         default: return PAN_W'($urandom_range(1, 32'hFFFF));
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return GAIN_W'(16'h1000);
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SMP_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return '0;
         default: return SMP_W'($urandom);
      endcase
   endfunction

   // random coefficients for all channels; bits above the register are noise
   task automatic program_random_coefs();
      logic [CSR_DATA_W-1:0] word;
      logic [CSR_DATA_W-1:0] fields;
      for (int i = 0; i < NUM_COEF_REGS; i++) begin
         word   = {$urandom, $urandom};
         fields = make_coef(pick_gain(), pick_pan(), pick_pan(),
                            1'($urandom_range(0, 1)));
         word[COEF_W-1:0] = fields[COEF_W-1:0];
         csr_write(i, word);
      end
   endtask

   // frames of 1..12 requests, tlast on the final one, some silent
   task automatic send_random_frames(input int n_items);
      int sent;
      int frame_len;
      sent = 0;
      while (sent < n_items) begin
         frame_len = $urandom_range(1, 12);
         for (int k = 0; k < frame_len; k++)
            send_request(CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)),
                         1'($urandom_range(0, 1)), pick_sample(),
                         $urandom_range(0, 99) < 8, k == frame_len - 1);
         sent += frame_len;
      end
   endtask

   initial begin : stimulus
      logic signed [SMP_W-1:0] full_scale;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_idle_pct = 11;
      recv_idle_pct = 56;
      hold_request  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);

      // one frame on the reset coefficients (mono, so both requests use the centre pan_l)
      send_request(0, 0, 16'sh7FFF, 0, 0);
      send_request(3, 1, -16'sd20000, 0, 1);
      wait_for_drain();

      // directed coefficient set
      csr_write(0, make_coef(16'h1000, PAN_HALF, PAN_ONE, 1'b0));     // centre, mono
      csr_write(1, make_coef(16'hFFFF, 17'h0, PAN_ONE, 1'b1));        // hard left / right
      csr_write(2, make_coef(16'h1000, PAN_ONE + 1, PAN_HALF, 1'b0)); // pan past 1.0
      csr_write(3, make_coef(16'h2000, 17'h04000, 17'h0C000, 1'b1));  // partial pans
      csr_write(4, make_coef(16'h0000, 17'h1FFFF, 17'h0, 1'b1));      // zero gain
      csr_write(5, make_coef(16'hFFFF, PAN_ONE, 17'h0, 1'b0));        // mono hard right
      csr_write(6, '1);                                               // every bit set
      csr_write(7, '0);                                               // every bit clear

      // directed frames
      send_request(0, 0, 16'sh7FFF, 0, 1);             // centre, positive full scale
      send_request(0, 1, 16'sh8000, 0, 1);             // mono on side 1 uses pan_l
      send_request(1, 0, 16'sh7FFF, 0, 0);             // stereo side 0 goes left
      send_request(1, 1, 16'sh7FFF, 0, 1);             // side 1 right, both clip
      send_request(1, 1, 16'sh8000, 0, 1);             // negative clip
      send_request(2, 0, 16'sd1234, 0, 0);             // pan beyond 1.0 mutes
      send_request(4, 1, 16'sh7FFF, 0, 1);             // zero gain
      send_request(3, 0, -16'sd12345, 0, 0);
      send_request(3, 1, 16'sd12345, 0, 1);
      send_request(5, 1, 16'sd20000, 0, 1);
      send_request(0, 0, 16'sh7FFF, 1, 1);             // silent request still emits
      send_request(6, 0, -16'sd1, 0, 0);
      send_request(6, 1, 16'sd1, 0, 1);
      send_request(7, 0, 16'sd5, 0, 0);
      send_request(3, 0, -16'sd1, 0, 1);               // negative rounds down
      send_request(0, 0, 16'sd0, 1, 1);                // frame with nothing in it
      send_request(0, 0, -16'sd1, 0, 1);
      wait_for_drain();

      // slow receiver, and one long hold-off so the input backs up
      program_random_coefs();
      hold_request = 1'b1;
      send_random_frames(PHASE_ITEMS);
      wait_for_drain();

      // slow sender, with a full pause halfway through
      send_idle_pct = 56;
      recv_idle_pct = 11;
      program_random_coefs();
      send_random_frames(PHASE_ITEMS / 2);
      wait_for_drain();
      send_random_frames(PHASE_ITEMS / 2);
      wait_for_drain();

      // no idling: one long frame first, full gain on both sides so the
      // outputs clip hard at the 16-bit limits
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < NUM_COEF_REGS; i++)
         csr_write(i, make_coef('1, PAN_HALF, PAN_HALF, 1'($urandom_range(0, 1))));
      full_scale = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      for (int k = 0; k < OVERFLOW_ITEMS; k++)
         send_request(CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)), 1'($urandom_range(0, 1)),
                      full_scale, 0, k == OVERFLOW_ITEMS - 1);
      wait_for_drain();
      program_random_coefs();
      send_random_frames(PHASE_ITEMS);
      wait_for_drain();

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: stereo_pan_gain_mixer.f
rtl/spgm_pkg.sv
rtl/spgm_csr.sv
rtl/spgm_dp.sv
rtl/spgm_ctrl.sv
rtl/stereo_pan_gain_mixer.sv
rtl/spgm_checker.sv
dv/spgm_mix_checker.sv
dv/tb_top.sv
